@@ hw/rtl/prq_pkg.sv @@
package prq_pkg;

	localparam logic [63:0] DUE_NOW_INTERVAL = 64'd1000;

	localparam logic [1:0] KIND_READY  = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_BLOCK  = 2'd2;
	localparam logic [1:0] KIND_CHECK  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_PRIO = 2'd1;
	localparam logic [1:0] ST_NO_TIMER = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  task_id;
		logic [4:0]  priority_req;
		logic [63:0] now_ns;
		logic [63:0] delay_ns;
	} item_t;

	typedef struct packed {
		logic        next_valid;
		logic [3:0]  head_task;
		logic        timer_pending;
		logic [63:0] timer_interval_ns;
		logic [4:0]  woken_count;
		logic [1:0]  status;
	} result_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_APPEND,
		OP_RM_HEAD,
		OP_RM_WALK,
		OP_TM_ARM,
		OP_TM_POS,
		OP_TM_WALK,
		OP_EXP_CHK,
		OP_EXP_APP,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       task_ok;
		logic       delay_nz;
		logic       rm_walk;
		logic       rm_done;
		logic       free_found;
		logic       count_zero;
		logic       pos_first;
		logic       walk_more;
		logic       exp_due;
	} stat_t;

endpackage

@@ hw/rtl/prq_dp.sv @@
module prq_dp #(
	parameter int TASK_SLOTS      = 16,
	parameter int PRIORITY_LEVELS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  prq_pkg::item_t   item,
	input  prq_pkg::cmd_t    cmd,
	output prq_pkg::stat_t   stat,
	output prq_pkg::result_t result
);

	localparam int TW = $clog2(TASK_SLOTS);
	localparam int LW = (PRIORITY_LEVELS > 2) ? $clog2(PRIORITY_LEVELS) : 1;
	localparam int CW = $clog2(TASK_SLOTS + 1);

	// control state
	logic [PRIORITY_LEVELS-1:0] mask_q;
	logic [TASK_SLOTS-1:0]      queued_q;
	logic [TASK_SLOTS-1:0]      used_q;
	logic [CW-1:0]              count_q;

	// payload stores
	logic [TW-1:0] head_q  [PRIORITY_LEVELS];
	logic [TW-1:0] tail_q  [PRIORITY_LEVELS];
	logic [TW-1:0] rlink_q [TASK_SLOTS];
	logic [LW-1:0] level_q [TASK_SLOTS];
	logic [63:0]   due_q   [TASK_SLOTS];
	logic [TW-1:0] owner_q [TASK_SLOTS];
	logic [TW-1:0] tlink_q [TASK_SLOTS];
	logic [TW-1:0] first_q;

	// item registers and walk pointers
	logic [1:0]    kind_q;
	logic [TW-1:0] t_q;
	logic          task_ok_q;
	logic [4:0]    prio_q;
	logic [63:0]   now_q;
	logic [63:0]   delay_q;
	logic [1:0]    status_q;
	logic [CW-1:0] woken_q;
	logic [LW-1:0] lvl_q;
	logic [TW-1:0] prev_q;
	logic [CW-1:0] n_q;
	logic [TW-1:0] s_q;
	logic [63:0]   due_s_q;
	logic [TW-1:0] cur_q;
	logic [CW-1:0] k_q;
	logic [TW-1:0] own_q;
	prq_pkg::result_t result_q;

	logic          prio_bad;
	logic [LW-1:0] lvl_t;
	logic [TW-1:0] nxt;
	logic [TW-1:0] free_s;
	logic          free_found;
	logic [TW-1:0] nl;
	logic          app_en;
	logic [TW-1:0] app_t;
	logic [LW-1:0] app_lvl;
	logic [LW-1:0] best_lvl;
	logic [63:0]   first_due;

	assign prio_bad  = 32'(prio_q) >= PRIORITY_LEVELS;
	assign lvl_t     = level_q[t_q];
	assign nxt       = rlink_q[prev_q];
	assign nl        = tlink_q[cur_q];
	assign first_due = due_q[first_q];

	always_comb begin
		free_s     = '0;
		free_found = 1'b0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_s     = TW'(i);
				free_found = 1'b1;
			end
		end
	end

	always_comb begin
		best_lvl = '0;
		for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				best_lvl = LW'(i);
			end
		end
	end

	always_comb begin
		app_en  = 1'b0;
		app_t   = t_q;
		app_lvl = LW'(prio_q);
		if (cmd.op == prq_pkg::OP_APPEND) begin
			app_en = !prio_bad && task_ok_q && !queued_q[t_q];
		end else if (cmd.op == prq_pkg::OP_EXP_APP) begin
			app_en  = !queued_q[own_q];
			app_t   = own_q;
			app_lvl = level_q[own_q];
		end
	end

	always_comb begin
		stat.kind       = kind_q;
		stat.task_ok    = task_ok_q;
		stat.delay_nz   = |delay_q;
		stat.rm_walk    = queued_q[t_q] && mask_q[lvl_t] && (head_q[lvl_t] != t_q);
		stat.rm_done    = (prev_q == tail_q[lvl_q]) || (nxt == t_q)
			|| (n_q == CW'(TASK_SLOTS - 1));
		stat.free_found = free_found;
		stat.count_zero = (count_q == '0);
		stat.pos_first  = due_s_q < first_due;
		stat.walk_more  = (k_q < count_q) && (due_q[nl] <= due_s_q);
		stat.exp_due    = (count_q != '0) && (first_due <= now_q);
	end

	// control state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			queued_q <= '0;
			used_q   <= '0;
			count_q  <= '0;
		end else begin
			unique case (cmd.op)
				prq_pkg::OP_RM_HEAD: begin
					if (queued_q[t_q]) begin
						queued_q[t_q] <= 1'b0;
						if (mask_q[lvl_t] && head_q[lvl_t] == t_q && tail_q[lvl_t] == t_q) begin
							mask_q[lvl_t] <= 1'b0;
						end
					end
				end
				prq_pkg::OP_TM_ARM: begin
					if (free_found) begin
						used_q[free_s] <= 1'b1;
						if (count_q == '0) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				prq_pkg::OP_TM_POS: begin
					if (stat.pos_first) begin
						count_q <= count_q + 1'b1;
					end
				end
				prq_pkg::OP_TM_WALK: begin
					if (!stat.walk_more) begin
						count_q <= count_q + 1'b1;
					end
				end
				prq_pkg::OP_EXP_CHK: begin
					if (stat.exp_due) begin
						used_q[first_q] <= 1'b0;
						count_q         <= count_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (app_en) begin
				mask_q[app_lvl] <= 1'b1;
				queued_q[app_t] <= 1'b1;
			end
		end
	end

	// payload stores and item registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			prq_pkg::OP_LOAD: begin
				kind_q    <= item.kind;
				t_q       <= TW'(item.task_id);
				task_ok_q <= 32'(item.task_id) < TASK_SLOTS;
				prio_q    <= item.priority_req;
				now_q     <= item.now_ns;
				delay_q   <= item.delay_ns;
				status_q  <= prq_pkg::ST_OK;
				woken_q   <= '0;
			end
			prq_pkg::OP_APPEND: begin
				if (prio_bad) begin
					status_q <= prq_pkg::ST_BAD_PRIO;
				end
			end
			prq_pkg::OP_RM_HEAD: begin
				lvl_q  <= lvl_t;
				prev_q <= head_q[lvl_t];
				n_q    <= '0;
				if (queued_q[t_q] && mask_q[lvl_t] && head_q[lvl_t] == t_q
						&& tail_q[lvl_t] != t_q) begin
					head_q[lvl_t] <= rlink_q[t_q];
				end
			end
			prq_pkg::OP_RM_WALK: begin
				if (prev_q != tail_q[lvl_q] && nxt == t_q) begin
					rlink_q[prev_q] <= rlink_q[t_q];
					if (tail_q[lvl_q] == t_q) begin
						tail_q[lvl_q] <= prev_q;
					end
				end else begin
					prev_q <= nxt;
					n_q    <= n_q + 1'b1;
				end
			end
			prq_pkg::OP_TM_ARM: begin
				if (free_found) begin
					due_q[free_s]   <= now_q + delay_q;
					owner_q[free_s] <= t_q;
					due_s_q         <= now_q + delay_q;
					s_q             <= free_s;
					if (count_q == '0) begin
						first_q <= free_s;
					end
				end else begin
					status_q <= prq_pkg::ST_NO_TIMER;
				end
			end
			prq_pkg::OP_TM_POS: begin
				cur_q <= first_q;
				k_q   <= CW'(1);
				if (stat.pos_first) begin
					tlink_q[s_q] <= first_q;
					first_q      <= s_q;
				end
			end
			prq_pkg::OP_TM_WALK: begin
				if (stat.walk_more) begin
					cur_q <= nl;
					k_q   <= k_q + 1'b1;
				end else begin
					tlink_q[s_q]   <= nl;
					tlink_q[cur_q] <= s_q;
				end
			end
			prq_pkg::OP_EXP_CHK: begin
				own_q <= owner_q[first_q];
				if (stat.exp_due) begin
					first_q <= tlink_q[first_q];
				end
			end
			prq_pkg::OP_EXP_APP: begin
				if (app_en) begin
					woken_q <= woken_q + 1'b1;
				end
			end
			prq_pkg::OP_RESULT: begin
				result_q.next_valid        <= |mask_q;
				result_q.head_task         <= (|mask_q) ? 4'(head_q[best_lvl]) : 4'd0;
				result_q.timer_pending     <= count_q != '0;
				result_q.timer_interval_ns <= (count_q == '0) ? 64'd0
					: (first_due > now_q) ? first_due - now_q : prq_pkg::DUE_NOW_INTERVAL;
				result_q.woken_count       <= 5'(woken_q);
				result_q.status            <= status_q;
			end
			default: begin
			end
		endcase
		if (app_en) begin
			if (mask_q[app_lvl]) begin
				rlink_q[tail_q[app_lvl]] <= app_t;
			end else begin
				head_q[app_lvl] <= app_t;
			end
			tail_q[app_lvl] <= app_t;
			level_q[app_t]  <= app_lvl;
		end
	end

	assign result = result_q;

endmodule

@@ hw/rtl/prq_ctrl.sv @@
module prq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  prq_pkg::stat_t stat,
	output prq_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_APP, S_RMH, S_RMW, S_ARM, S_POS, S_TWALK, S_EXPC, S_EXPA, S_RES
	} state_t;

	state_t state_q;
	logic   done_q;

	always_comb begin
		unique case (state_q)
			S_IDLE:  cmd.op = start ? prq_pkg::OP_LOAD : prq_pkg::OP_NONE;
			S_DISP:  cmd.op = prq_pkg::OP_NONE;
			S_APP:   cmd.op = prq_pkg::OP_APPEND;
			S_RMH:   cmd.op = prq_pkg::OP_RM_HEAD;
			S_RMW:   cmd.op = prq_pkg::OP_RM_WALK;
			S_ARM:   cmd.op = prq_pkg::OP_TM_ARM;
			S_POS:   cmd.op = prq_pkg::OP_TM_POS;
			S_TWALK: cmd.op = prq_pkg::OP_TM_WALK;
			S_EXPC:  cmd.op = prq_pkg::OP_EXP_CHK;
			S_EXPA:  cmd.op = prq_pkg::OP_EXP_APP;
			S_RES:   cmd.op = prq_pkg::OP_RESULT;
			default: cmd.op = prq_pkg::OP_NONE;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_DISP;
				end
				S_DISP: begin
					unique case (stat.kind)
						prq_pkg::KIND_READY:  state_q <= S_APP;
						prq_pkg::KIND_REMOVE: state_q <= stat.task_ok ? S_RMH : S_RES;
						prq_pkg::KIND_BLOCK:
							state_q <= (stat.task_ok && stat.delay_nz) ? S_RMH : S_RES;
						default:              state_q <= S_EXPC;
					endcase
				end
				S_APP: state_q <= S_RES;
				S_RMH: begin
					if (stat.rm_walk) state_q <= S_RMW;
					else state_q <= (stat.kind == prq_pkg::KIND_BLOCK) ? S_ARM : S_RES;
				end
				S_RMW: begin
					if (stat.rm_done) begin
						state_q <= (stat.kind == prq_pkg::KIND_BLOCK) ? S_ARM : S_RES;
					end
				end
				S_ARM: state_q <= (stat.free_found && !stat.count_zero) ? S_POS : S_RES;
				S_POS: state_q <= stat.pos_first ? S_RES : S_TWALK;
				S_TWALK: begin
					if (!stat.walk_more) state_q <= S_RES;
				end
				S_EXPC: state_q <= stat.exp_due ? S_EXPA : S_RES;
				S_EXPA: state_q <= S_EXPC;
				S_RES: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/priority_ready_queue_with_timed_wakeup.sv @@
// channel | signals             | handshake
// --------+---------------------+-------------------------------
// item    | item (item_t)       | beat taken when start && !busy
// result  | result (result_t)   | one-cycle beat marked by done
//
// Make-ready appends the task directly. Remove walks the ready list node by node;
// block adds that walk, an arm step, a head test when other timers are armed
// and a walk over the timer list; a timer check tests and wakes expired timers
// one after another.
// Reset clears the ready mask, queued and timer-used flags and the timer count.
// done may show in the same cycle a new item is accepted; the receiver cannot stall.
module priority_ready_queue_with_timed_wakeup #(
	parameter int TASK_SLOTS      = 16,
	parameter int PRIORITY_LEVELS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  prq_pkg::item_t   item,
	output logic             done,
	output prq_pkg::result_t result
);

	prq_pkg::cmd_t  cmd;
	prq_pkg::stat_t stat;

	prq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	prq_dp #(
		.TASK_SLOTS      (TASK_SLOTS),
		.PRIORITY_LEVELS (PRIORITY_LEVELS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

@@ hw/rtl/prq_chk.sv @@
module prq_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input prq_pkg::result_t result
);

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held more than one cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= prq_pkg::ST_NO_TIMER)
		else $error("bad status code");

	a_empty_task: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.next_valid |-> result.head_task == 4'd0)
		else $error("task shown with no ready task");

endmodule

bind priority_ready_queue_with_timed_wakeup prq_chk u_prq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

@@ dv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS  = 16;
	localparam int LEVELS = 32;
	localparam int RANDOM_ITEMS = 850;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	prq_pkg::item_t   item;
	logic             done;
	prq_pkg::result_t result;

	priority_ready_queue_with_timed_wakeup dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	// scheduler shadow state
	logic [31:0] lvl_mask;
	logic [3:0]  lvl_head [LEVELS];
	logic [3:0]  lvl_tail [LEVELS];
	logic [3:0]  rdy_next [SLOTS];
	logic [4:0]  prio_of [SLOTS];
	bit          queued [SLOTS];
	bit          prio_known [SLOTS];
	logic [63:0] tmr_due [SLOTS];
	logic [3:0]  tmr_task [SLOTS];
	bit          tmr_busy [SLOTS];
	logic [3:0]  tmr_next [SLOTS];
	logic [3:0]  tmr_head;
	int          tmr_cnt;

	prq_pkg::result_t sched_expected [$];
	int               errors;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic void shadow_append(input int t, input int lvl);
		if (lvl_mask[lvl]) rdy_next[lvl_tail[lvl]] = t[3:0];
		else lvl_head[lvl] = t[3:0];
		lvl_tail[lvl] = t[3:0];
		lvl_mask[lvl] = 1'b1;
		queued[t] = 1;
		prio_of[t] = lvl[4:0];
		prio_known[t] = 1;
	endfunction

	function automatic void shadow_remove(input int t);
		int lvl;
		int prev;
		int nxt;
		if (!queued[t]) return;
		lvl = prio_of[t];
		queued[t] = 0;
		if (!lvl_mask[lvl]) return;
		if (lvl_head[lvl] == t) begin
			if (lvl_tail[lvl] == t) lvl_mask[lvl] = 1'b0;
			else lvl_head[lvl] = rdy_next[t];
			return;
		end
		prev = lvl_head[lvl];
		for (int n = 0; n < SLOTS; n++) begin
			if (prev == lvl_tail[lvl]) break;
			nxt = rdy_next[prev];
			if (nxt == t) begin
				rdy_next[prev] = rdy_next[t];
				if (lvl_tail[lvl] == t) lvl_tail[lvl] = prev[3:0];
				break;
			end
			prev = nxt;
		end
	endfunction

	function automatic void shadow_arm(input int s);
		int cur;
		int k;
		if (tmr_cnt == 0) tmr_head = s[3:0];
		else if (tmr_due[s] < tmr_due[tmr_head]) begin
			tmr_next[s] = tmr_head;
			tmr_head = s[3:0];
		end else begin
			cur = tmr_head;
			k = 1;
			while (k < tmr_cnt && tmr_due[tmr_next[cur]] <= tmr_due[s]) begin
				cur = tmr_next[cur];
				k++;
			end
			tmr_next[s] = tmr_next[cur];
			tmr_next[cur] = s[3:0];
		end
		tmr_cnt++;
	endfunction

	function automatic prq_pkg::result_t schedule_step(input prq_pkg::item_t it);
		prq_pkg::result_t r;
		int t;
		int s;
		int woken;
		r = '0;
		woken = 0;
		t = it.task_id;
		case (it.kind)
			prq_pkg::KIND_READY: begin
				if (!queued[t]) shadow_append(t, it.priority_req);
			end
			prq_pkg::KIND_REMOVE: shadow_remove(t);
			prq_pkg::KIND_BLOCK: begin
				if (it.delay_ns != 0) begin
					shadow_remove(t);
					s = 0;
					while (s < SLOTS && tmr_busy[s]) s++;
					if (s >= SLOTS) r.status = prq_pkg::ST_NO_TIMER;
					else begin
						tmr_due[s] = it.now_ns + it.delay_ns;
						tmr_task[s] = t[3:0];
						tmr_busy[s] = 1;
						shadow_arm(s);
					end
				end
			end
			default: begin
				while (tmr_cnt > 0 && tmr_due[tmr_head] <= it.now_ns) begin
					s = tmr_head;
					tmr_head = tmr_next[s];
					tmr_busy[s] = 0;
					tmr_cnt--;
					t = tmr_task[s];
					if (!queued[t]) begin
						shadow_append(t, prio_of[t]);
						woken++;
					end
				end
			end
		endcase
		if (lvl_mask != 0) begin
			for (int l = 0; l < LEVELS; l++)
				if (lvl_mask[l]) begin
					r.next_valid = 1'b1;
					r.head_task = lvl_head[l];
					break;
				end
		end
		if (tmr_cnt > 0) begin
			r.timer_pending = 1'b1;
			r.timer_interval_ns = (tmr_due[tmr_head] > it.now_ns) ?
				tmr_due[tmr_head] - it.now_ns : prq_pkg::DUE_NOW_INTERVAL;
		end
		r.woken_count = woken[4:0];
		return r;
	endfunction

	// directed rows; golden result typed in where obvious
	typedef struct {
		prq_pkg::item_t   it;
		bit               has_gold;
		prq_pkg::result_t gold;
	} dir_row_t;

	dir_row_t dir_rows [$];

	function automatic prq_pkg::item_t mk(input logic [1:0] k, input int t, input int p,
			input logic [63:0] now, input logic [63:0] dly);
		prq_pkg::item_t it;
		it.kind = k;
		it.task_id = t[3:0];
		it.priority_req = p[4:0];
		it.now_ns = now;
		it.delay_ns = dly;
		return it;
	endfunction

	task automatic add_row(input prq_pkg::item_t it, input bit g, input prq_pkg::result_t r);
		dir_row_t d;
		d.it = it;
		d.has_gold = g;
		d.gold = r;
		dir_rows.push_back(d);
	endtask

	// Drive one beat and hold it until taken.
	task automatic send_item(input prq_pkg::item_t it, input bit has_gold,
			input prq_pkg::result_t gold);
		prq_pkg::result_t e;
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		e = schedule_step(it);
		if (has_gold && e !== gold)
			report_mismatch($sformatf("shadow disagrees with typed result %h", gold));
		sched_expected.push_back(has_gold ? gold : e);
	endtask

	task automatic idle_gap();
		start <= 1'b0;
		repeat ($urandom_range(1, 20)) @(posedge clk);
	endtask

	// tasks whose level is known; woken tasks must have one
	function automatic int pick_known();
		int t;
		for (int n = 0; n < 64; n++) begin
			t = $urandom_range(0, SLOTS - 1);
			if (prio_known[t]) return t;
		end
		for (int i = 0; i < SLOTS; i++) if (prio_known[i]) return i;
		return -1;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	always @(posedge clk) begin
		prq_pkg::result_t e;
		if (arst_n && done) begin
			if (sched_expected.size() == 0) report_mismatch("result with none expected");
			else begin
				e = sched_expected.pop_front();
				if (result.next_valid !== e.next_valid)
					report_mismatch($sformatf("next_valid %b exp %b", result.next_valid,
						e.next_valid));
				if (result.head_task !== e.head_task)
					report_mismatch($sformatf("head_task %0d exp %0d", result.head_task,
						e.head_task));
				if (result.timer_pending !== e.timer_pending)
					report_mismatch($sformatf("timer_pending %b exp %b",
						result.timer_pending, e.timer_pending));
				if (result.timer_interval_ns !== e.timer_interval_ns)
					report_mismatch($sformatf("interval %0d exp %0d",
						result.timer_interval_ns, e.timer_interval_ns));
				if (result.woken_count !== e.woken_count)
					report_mismatch($sformatf("woken %0d exp %0d", result.woken_count,
						e.woken_count));
				if (result.status !== e.status)
					report_mismatch($sformatf("status %0d exp %0d", result.status,
						e.status));
			end
		end
	end

	initial begin
		#50ms;
		$display("priority_ready_queue_with_timed_wakeup test failed");
		$finish;
	end

	initial begin
		prq_pkg::result_t z;
		prq_pkg::item_t   it;
		int      burst;
		int      t;
		int      r;
		int      waited;
		logic [63:0] now;
		errors = 0;
		lvl_mask = '0;
		tmr_cnt = 0;
		tmr_head = '0;
		for (int i = 0; i < LEVELS; i++) begin
			lvl_head[i] = '0;
			lvl_tail[i] = '0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			rdy_next[i] = '0; prio_of[i] = '0; queued[i] = 0; prio_known[i] = 0;
			tmr_due[i] = '0; tmr_task[i] = '0; tmr_busy[i] = 0; tmr_next[i] = '0;
		end
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		z = '0;
		add_row(mk(prq_pkg::KIND_CHECK, 0, 0, 64'd0, 64'd0), 1, z);
		add_row(mk(prq_pkg::KIND_REMOVE, 15, 31, '1, '1), 1, z);
		z.next_valid = 1'b1; z.head_task = 4'd15;
		add_row(mk(prq_pkg::KIND_READY, 15, 31, 64'd0, 64'd0), 1, z);
		add_row(mk(prq_pkg::KIND_READY, 15, 0, 64'd0, 64'd0), 1, z);
		add_row(mk(prq_pkg::KIND_READY, 0, 0, '1, '1), 0, z);
		add_row(mk(prq_pkg::KIND_READY, 7, 0, 64'd5, 64'd0), 0, z);
		add_row(mk(prq_pkg::KIND_READY, 3, 16, 64'd5, 64'd0), 0, z);
		add_row(mk(prq_pkg::KIND_REMOVE, 7, 0, 64'd0, 64'd0), 0, z);
		add_row(mk(prq_pkg::KIND_BLOCK, 0, 0, 64'd100, 64'd0), 0, z);
		add_row(mk(prq_pkg::KIND_BLOCK, 0, 0, 64'd100, 64'd50), 0, z);
		add_row(mk(prq_pkg::KIND_BLOCK, 7, 0, 64'd100, 64'd50), 0, z);
		add_row(mk(prq_pkg::KIND_BLOCK, 3, 0, 64'd100, 64'd10), 0, z);
		add_row(mk(prq_pkg::KIND_BLOCK, 15, 0, '1, 64'd2), 0, z);
		add_row(mk(prq_pkg::KIND_READY, 3, 9, 64'd100, 64'd0), 0, z);
		add_row(mk(prq_pkg::KIND_CHECK, 0, 0, 64'd120, 64'd0), 0, z);
		add_row(mk(prq_pkg::KIND_CHECK, 0, 0, 64'd150, 64'd0), 0, z);
		add_row(mk(prq_pkg::KIND_CHECK, 0, 0, '1, '1), 0, z);
		// only tasks with a known level get timers
		for (int i = 0; i < 17; i++)
			add_row(mk(prq_pkg::KIND_BLOCK, (i % 2) * 7, 0, 64'd200, 64'd1000 + i % 3),
				0, z);
		add_row(mk(prq_pkg::KIND_CHECK, 0, 0, 64'd100, 64'd0), 0, z);
		add_row(mk(prq_pkg::KIND_CHECK, 0, 0, 64'd1300, 64'd0), 0, z);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].it, dir_rows[i].has_gold, dir_rows[i].gold);
			if ($urandom_range(0, 2) == 0) idle_gap();
		end

		now = 64'd2000;
		r = 0;
		while (r < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && r < RANDOM_ITEMS; b++) begin
				now += $urandom_range(0, 300);
				it = mk(prq_pkg::KIND_READY, $urandom_range(0, SLOTS - 1),
					$urandom_range(0, 31), now, 64'd0);
				case ($urandom_range(0, 9))
					0, 1, 2: ;
					3: it.kind = prq_pkg::KIND_REMOVE;
					4, 5: begin
						t = pick_known();
						if (t >= 0) begin
							it.kind = prq_pkg::KIND_BLOCK;
							it.task_id = t[3:0];
							it.delay_ns = ($urandom_range(0, 15) == 0) ?
								(($urandom_range(0, 1)) ? 64'd0 : rand64()) :
								64'($urandom_range(1, 1500));
						end
					end
					6: begin
						// noise fields on remove
						it.kind = prq_pkg::KIND_REMOVE;
						it.delay_ns = rand64();
						it.now_ns = rand64();
					end
					default: begin
						it.kind = prq_pkg::KIND_CHECK;
						if ($urandom_range(0, 20) == 0) it.now_ns = rand64();
					end
				endcase
				send_item(it, 0, '0);
				r++;
			end
			if ($urandom_range(0, 3) != 0) idle_gap();
		end
		start <= 1'b0;

		waited = 0;
		while (sched_expected.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (3 + 2 * SLOTS + 10) @(posedge clk);
		if (errors == 0 && sched_expected.size() == 0)
			$display("priority_ready_queue_with_timed_wakeup test passed");
		else
			$display("priority_ready_queue_with_timed_wakeup test failed");
		$finish;
	end

endmodule
